// File: rtl/nsu8_pkg.sv
// shared types, constants and encoding functions for the name string transcoder
package nsu8_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic ENC_UTF16BE  = 1'b0;
    localparam logic ENC_ROMAN    = 1'b1;

    localparam logic [15:0] REPLACEMENT_CP = 16'hFFFD;
    localparam logic [20:0] SUPP_BASE      = 21'h010000;
    localparam logic [5:0]  HIGH_SURR_TAG  = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG   = 6'b110111;

    localparam logic [15:0] ROMAN_MAP [0:127] = '{
        16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
        16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
        16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
        16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
        16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
        16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
        16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
        16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
        16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
        16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
        16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
        16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
        16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
        16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
        16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
        16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
    };

    // up to two code points caused by one input byte
    typedef struct packed {
        logic [20:0] cp0;
        logic        mal0;
        logic        v0;
        logic [15:0] cp1;
        logic        mal1;
        logic        v1;
        logic        last;
    } nsu8_entry_t;

    // number of utf-8 bytes minus one
    function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
        logic [1:0] n;
        if (cp < 21'h000080) begin
            n = 2'd0;
        end else if (cp < 21'h000800) begin
            n = 2'd1;
        end else if (cp < 21'h010000) begin
            n = 2'd2;
        end else begin
            n = 2'd3;
        end
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte_at(input logic [20:0] cp,
                                                input logic [1:0] len_m1,
                                                input logic [1:0] idx);
        logic [7:0] b;
        logic [1:0] grp;
        grp = len_m1 - idx;
        if (idx == 2'd0) begin
            case (len_m1)
                2'd0:    b = {1'b0, cp[6:0]};
                2'd1:    b = {3'b110, cp[10:6]};
                2'd2:    b = {4'b1110, cp[15:12]};
                2'd3:    b = {5'b11110, cp[20:18]};
                default: b = 8'h00;
            endcase
        end else begin
            case (grp)
                2'd0:    b = {2'b10, cp[5:0]};
                2'd1:    b = {2'b10, cp[11:6]};
                2'd2:    b = {2'b10, cp[17:12]};
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

// File: rtl/nsu8_front.sv
// front end: input transfer, decoding state and classification into code point entries
module nsu8_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  logic               q_full,
    output logic               push,
    output nsu8_pkg::nsu8_entry_t entry
);
    import nsu8_pkg::*;

    logic        enc_reg, enc_next;
    logic [7:0]  held_reg, held_next;
    logic        have_held_reg, have_held_next;
    logic [9:0]  pend_reg, pend_next;
    logic        pend_v_reg, pend_v_next;

    logic [15:0] unit;
    logic        is_high, is_low, pair, pend_fail, pend_after;
    logic        a_v, b_v, c_v, a_mal, b_mal;
    logic [20:0] a_cp;
    logic [15:0] b_cp;
    logic        accept;

    always_comb
    begin
        unit       = {held_reg, data_byte};
        is_high    = unit[15:10] == HIGH_SURR_TAG;
        is_low     = unit[15:10] == LOW_SURR_TAG;
        pair       = have_held_reg && pend_v_reg && is_low;
        pend_fail  = have_held_reg && pend_v_reg && !is_low;
        pend_after = have_held_reg ? (!pair && is_high) : pend_v_reg;

        a_v   = pair || pend_fail;
        a_cp  = pair ? (SUPP_BASE + {1'b0, pend_reg, unit[9:0]}) : {5'b0, REPLACEMENT_CP};
        a_mal = pend_fail;
        b_v   = have_held_reg && !is_high && !pair;
        b_cp  = is_low ? REPLACEMENT_CP : unit;
        b_mal = is_low;
        c_v   = last_byte && pend_after;

        entry.last = last_byte;
        if (enc_reg == ENC_ROMAN) begin
            entry.v0   = 1'b1;
            entry.cp0  = data_byte[7] ? {5'b0, ROMAN_MAP[data_byte[6:0]]}
                                      : {13'b0, data_byte};
            entry.mal0 = 1'b0;
            entry.v1   = 1'b0;
            entry.cp1  = 16'h0000;
            entry.mal1 = 1'b0;
        end else begin
            entry.v0   = a_v || b_v || c_v;
            entry.cp0  = a_v ? a_cp : (b_v ? {5'b0, b_cp} : {5'b0, REPLACEMENT_CP});
            entry.mal0 = a_v ? a_mal : (b_v ? b_mal : 1'b1);
            entry.v1   = a_v && (b_v || c_v);
            entry.cp1  = b_v ? b_cp : REPLACEMENT_CP;
            entry.mal1 = b_v ? b_mal : 1'b1;
        end

        in_stall = q_full;
        accept   = in_valid && !q_full;
        push     = accept && (entry.v0 || last_byte);

        enc_next       = enc_reg;
        held_next      = held_reg;
        have_held_next = have_held_reg;
        pend_next      = pend_reg;
        pend_v_next    = pend_v_reg;
        if (cfg_we) begin
            enc_next       = cfg_wdata;
            have_held_next = 1'b0;
            pend_v_next    = 1'b0;
        end else if (accept) begin
            if (last_byte) begin
                have_held_next = 1'b0;
                pend_v_next    = 1'b0;
            end else if (enc_reg == ENC_UTF16BE) begin
                if (have_held_reg) begin
                    have_held_next = 1'b0;
                    pend_v_next    = pend_after;
                    if (is_high && !pair) begin
                        pend_next = unit[9:0];
                    end
                end else begin
                    held_next      = data_byte;
                    have_held_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            enc_reg       <= ENC_UTF16BE;
            have_held_reg <= 1'b0;
            pend_v_reg    <= 1'b0;
        end else begin
            enc_reg       <= enc_next;
            have_held_reg <= have_held_next;
            pend_v_reg    <= pend_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        pend_reg <= pend_next;
    end

endmodule

// File: rtl/nsu8_queue.sv
// short entry queue between front and back
module nsu8_queue #(
    parameter int DEPTH = nsu8_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  nsu8_pkg::nsu8_entry_t push_entry,
    input  logic                  pop,
    output logic                  not_empty,
    output logic                  full,
    output nsu8_pkg::nsu8_entry_t head
);
    import nsu8_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    nsu8_entry_t   mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        not_empty   = count_reg != '0;
        full        = count_reg == FULL_CNT;
        head        = mem_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/nsu8_back.sv
// back end: utf-8 byte sequencer and output register
module nsu8_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  nsu8_pkg::nsu8_entry_t e,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            utf8_byte,
    output logic                  byte_valid,
    output logic                  char_end,
    output logic                  string_end,
    output logic                  malformed
);
    import nsu8_pkg::*;

    logic        phase_reg, phase_next;
    logic [1:0]  idx_reg, idx_next;
    logic        ov_reg, ov_next;
    logic [7:0]  ob_reg, ob_next;
    logic        obv_reg, obv_next;
    logic        oce_reg, oce_next;
    logic        ose_reg, ose_next;
    logic        omal_reg, omal_next;

    logic        sel1, cur_has, cur_mal, cp_done, entry_done, load;
    logic [20:0] cur_cp;
    logic [1:0]  len_m1;

    always_comb
    begin
        sel1       = phase_reg || !e.v0;
        cur_cp     = sel1 ? {5'b0, e.cp1} : e.cp0;
        cur_mal    = sel1 ? e.mal1 : e.mal0;
        cur_has    = sel1 ? e.v1 : e.v0;
        len_m1     = utf8_len_m1(cur_cp);
        cp_done    = idx_reg == len_m1;
        entry_done = !cur_has || (cp_done && (sel1 || !e.v1));
        load       = q_valid && (!ov_reg || !out_stall);
        pop        = load && entry_done;

        phase_next = phase_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg && out_stall;
        ob_next    = ob_reg;
        obv_next   = obv_reg;
        oce_next   = oce_reg;
        ose_next   = ose_reg;
        omal_next  = omal_reg;
        if (load) begin
            ov_next   = 1'b1;
            ob_next   = cur_has ? utf8_byte_at(cur_cp, len_m1, idx_reg) : 8'h00;
            obv_next  = cur_has;
            oce_next  = cur_has && cp_done;
            ose_next  = entry_done && e.last;
            omal_next = cur_has && cur_mal;
            if (entry_done) begin
                phase_next = 1'b0;
                idx_next   = 2'd0;
            end else if (cp_done) begin
                phase_next = 1'b1;
                idx_next   = 2'd0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end

        out_valid  = ov_reg;
        utf8_byte  = ob_reg;
        byte_valid = obv_reg;
        char_end   = oce_reg;
        string_end = ose_reg;
        malformed  = omal_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= 1'b0;
            idx_reg   <= 2'd0;
            ov_reg    <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg   <= ob_next;
        obv_reg  <= obv_next;
        oce_reg  <= oce_next;
        ose_reg  <= ose_next;
        omal_reg <= omal_next;
    end

endmodule

// File: rtl/name_string_to_utf8_transcoder_core.sv
// top level of the name string to utf-8 transcoder
//
// input channel: in_valid/in_stall carry data_byte and last_byte, one string byte per transfer
// output channel: out_valid/out_stall carry one utf-8 byte per transfer with its flags
// cfg_we/cfg_wdata write the source encoding (0 utf-16be, 1 roman single byte);
// a write also drops any partial unit or pending surrogate
// the front decodes each input byte in the cycle it is taken and pushes up to two
// code points into a queue of QUEUE_DEPTH entries; the back spells them out in utf-8
// each accepted byte passes through the queue and then the output register
// throughput: one input byte per cycle while the queue has room, one output byte per
// cycle while out_stall is low; the output port is the limit, so an input byte that
// expands to k utf-8 bytes holds its queue entry until all k of them have gone out
// a final byte with nothing to emit gives one bare end marker
// reset: queue empty, no output valid, utf-16be selected, no string state
// when out_stall is high the output register holds; the queue fills and in_stall rises
module name_string_to_utf8_transcoder_core #(
    parameter int QUEUE_DEPTH = nsu8_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] utf8_byte,
    output logic       byte_valid,
    output logic       char_end,
    output logic       string_end,
    output logic       malformed
);
    import nsu8_pkg::*;

    nsu8_entry_t push_entry;
    nsu8_entry_t head;
    logic        push, pop, q_full, q_not_empty;

    nsu8_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .push      (push),
        .entry     (push_entry)
    );

    nsu8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .full       (q_full),
        .head       (head)
    );

    nsu8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .e          (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .utf8_byte  (utf8_byte),
        .byte_valid (byte_valid),
        .char_end   (char_end),
        .string_end (string_end),
        .malformed  (malformed)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full))
        else $error("push into full queue");

    a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> string_end && !char_end && !malformed && utf8_byte == 8'h00)
        else $error("bad end marker");

    a_malformed_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && malformed |->
            utf8_byte == 8'hEF || utf8_byte == 8'hBF || utf8_byte == 8'hBD)
        else $error("malformed byte not a replacement character");

    a_end_on_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end && byte_valid |-> char_end)
        else $error("string end inside a character");

endmodule

// File: test/tb_name_string_to_utf8_transcoder_core.sv
// testbench for the name string to utf-8 transcoder: directed and random strings checked against a predictor
module tb_name_string_to_utf8_transcoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import nsu8_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT = 22;
    localparam logic [5:0] HI_SURR_TAG = 6'b110110;
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;
    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;

    localparam logic [15:0] ROMAN_UPPER [128] = '{
        16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
        16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
        16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
        16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
        16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
        16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
        16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
        16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
        16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
        16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
        16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
        16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
        16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
        16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
        16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
        16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } name_byte_t;

    typedef struct packed {
        logic [7:0] ubyte;
        logic       bvalid;
        logic       cend;
        logic       send;
        logic       mal;
    } utf8_out_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] utf8_byte;
    logic       byte_valid;
    logic       char_end;
    logic       string_end;
    logic       malformed;

    name_byte_t string_feed[$];
    utf8_out_t  utf8_expected[$];
    utf8_out_t  seen_byte;
    utf8_out_t  want_byte;
    name_byte_t next_byte;
    int         idle_pct = IDLE_PCT;
    int         mismatch_count = 0;
    int         cycle_count = 0;

    // predictor state
    logic       enc_sel = ENC_UTF16BE;
    logic [7:0] held_hi = 8'h00;
    logic       held_ok = 1'b0;
    logic [9:0] pend_surr = 10'h000;
    logic       pend_ok = 1'b0;

    name_string_to_utf8_transcoder_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .utf8_byte  (utf8_byte),
        .byte_valid (byte_valid),
        .char_end   (char_end),
        .string_end (string_end),
        .malformed  (malformed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_string_state();
        held_hi = 8'h00;
        held_ok = 1'b0;
        pend_surr = 10'h000;
        pend_ok = 1'b0;
    endfunction

    function automatic void push_utf8(logic [7:0] b, logic ce, logic mal);
        utf8_out_t r;
        r.ubyte = b;
        r.bvalid = 1'b1;
        r.cend = ce;
        r.send = 1'b0;
        r.mal = mal;
        utf8_expected.push_back(r);
    endfunction

    function automatic int emit_code_point(logic [20:0] cp, logic mal);
        if (cp < 21'h000080) begin
            push_utf8({1'b0, cp[6:0]}, 1'b1, mal);
            return 1;
        end
        if (cp < 21'h000800) begin
            push_utf8({3'b110, cp[10:6]}, 1'b0, mal);
            push_utf8({2'b10, cp[5:0]}, 1'b1, mal);
            return 2;
        end
        if (cp < 21'h010000) begin
            push_utf8({4'b1110, cp[15:12]}, 1'b0, mal);
            push_utf8({2'b10, cp[11:6]}, 1'b0, mal);
            push_utf8({2'b10, cp[5:0]}, 1'b1, mal);
            return 3;
        end
        push_utf8({5'b11110, cp[20:18]}, 1'b0, mal);
        push_utf8({2'b10, cp[17:12]}, 1'b0, mal);
        push_utf8({2'b10, cp[11:6]}, 1'b0, mal);
        push_utf8({2'b10, cp[5:0]}, 1'b1, mal);
        return 4;
    endfunction

    function automatic void transcode_byte(logic [7:0] b, logic lst);
        logic [15:0] unit;
        logic        is_hi;
        logic        is_lo;
        int          n;
        n = 0;
        if (enc_sel == ENC_ROMAN) begin
            if (b < 8'h80) begin
                n += emit_code_point({13'd0, b}, 1'b0);
            end else begin
                n += emit_code_point({5'd0, ROMAN_UPPER[b[6:0]]}, 1'b0);
            end
        end else begin
            if (held_ok) begin
                unit = {held_hi, b};
                held_ok = 1'b0;
                held_hi = 8'h00;
                is_hi = unit[15:10] == HI_SURR_TAG;
                is_lo = unit[15:10] == LO_SURR_TAG;
                if (pend_ok && is_lo) begin
                    n += emit_code_point(21'h010000 + {pend_surr, unit[9:0]}, 1'b0);
                    pend_ok = 1'b0;
                    pend_surr = 10'h000;
                end else begin
                    if (pend_ok) begin
                        n += emit_code_point(REPLACEMENT, 1'b1);
                        pend_ok = 1'b0;
                        pend_surr = 10'h000;
                    end
                    if (is_hi) begin
                        pend_surr = unit[9:0];
                        pend_ok = 1'b1;
                    end else if (is_lo) begin
                        n += emit_code_point(REPLACEMENT, 1'b1);
                    end else begin
                        n += emit_code_point({5'd0, unit}, 1'b0);
                    end
                end
            end else begin
                held_hi = b;
                held_ok = 1'b1;
            end
            if (lst && pend_ok) begin
                n += emit_code_point(REPLACEMENT, 1'b1);
            end
        end
        if (lst) begin
            clear_string_state();
            // bare end marker
            if (n == 0) begin
                utf8_expected.push_back('0);
            end
            utf8_expected[utf8_expected.size() - 1].send = 1'b1;
        end
    endfunction

    // input side: one transfer per accepted byte
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                transcode_byte(data_byte, last_byte);
            end
            if (!in_valid || !in_stall) begin
                if (string_feed.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    next_byte = string_feed.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= next_byte.data;
                    last_byte <= next_byte.last;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                seen_byte = {utf8_byte, byte_valid, char_end, string_end, malformed};
                if (utf8_expected.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected: byte %h valid %b cend %b send %b mal %b",
                                 seen_byte.ubyte, seen_byte.bvalid, seen_byte.cend,
                                 seen_byte.send, seen_byte.mal);
                    end
                end else begin
                    want_byte = utf8_expected.pop_front();
                    if (seen_byte !== want_byte) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("expected byte %h valid %b cend %b send %b mal %b",
                                     want_byte.ubyte, want_byte.bvalid, want_byte.cend,
                                     want_byte.send, want_byte.mal);
                            $display("got      byte %h valid %b cend %b send %b mal %b",
                                     seen_byte.ubyte, seen_byte.bvalid, seen_byte.cend,
                                     seen_byte.send, seen_byte.mal);
                        end
                    end
                end
            end
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_string(logic [7:0] bytes[$]);
        name_byte_t item;
        for (int i = 0; i < bytes.size(); i++) begin
            item.data = bytes[i];
            item.last = (i == bytes.size() - 1);
            string_feed.push_back(item);
        end
    endtask

    task automatic add_utf16_string();
        logic [7:0]  bytes[$];
        logic [15:0] units[$];
        logic [9:0]  r10;
        int          count;
        count = $urandom_range(1, 10);
        repeat (count) begin
            r10 = 10'($urandom_range(1023));
            case ($urandom_range(7))
                0: units.push_back(16'($urandom_range(16'h007F)));
                1: units.push_back(16'($urandom_range(16'h07FF, 16'h0080)));
                2: units.push_back(16'($urandom_range(16'hFFFF, 16'h0800)));
                3, 4:
                begin
                    units.push_back({HI_SURR_TAG, r10});
                    r10 = 10'($urandom_range(1023));
                    units.push_back({LO_SURR_TAG, r10});
                end
                5: units.push_back({HI_SURR_TAG, r10});
                6: units.push_back({LO_SURR_TAG, r10});
                default: units.push_back(16'($urandom_range(16'hFFFF)));
            endcase
        end
        foreach (units[i]) begin
            bytes.push_back(units[i][15:8]);
            bytes.push_back(units[i][7:0]);
        end
        // odd trailing byte now and then
        if ($urandom_range(5) == 0) begin
            bytes.push_back(8'($urandom_range(255)));
        end
        push_string(bytes);
    endtask

    task automatic add_roman_string();
        logic [7:0] bytes[$];
        int         count;
        count = $urandom_range(1, 8);
        repeat (count) bytes.push_back(8'($urandom_range(255)));
        push_string(bytes);
    endtask

    task automatic wait_drained();
        while (string_feed.size() != 0 || in_valid || utf8_expected.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_encoding(logic enc);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= enc;
        @(posedge clk);
        cfg_we <= 1'b0;
        enc_sel = enc;
        clear_string_state();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // utf-16: ascii, zero, 2/3-byte edges, max unit, pairs, broken surrogates, pending at end
        push_string('{8'h00, 8'h41, 8'h00, 8'h00, 8'h07, 8'hFF, 8'h08, 8'h00,
                      8'hFF, 8'hFF, 8'hD8, 8'h00, 8'hDC, 8'h00, 8'hDB, 8'hFF,
                      8'hDF, 8'hFF, 8'hD8, 8'h3D, 8'h00, 8'h41, 8'hDC, 8'h00,
                      8'hD8, 8'h01});
        // odd trailing byte alone gives a bare end marker
        push_string('{8'h41});
        wait_drained();

        write_encoding(ENC_ROMAN);
        push_string('{8'h00, 8'h7F, 8'h80, 8'hFF, 8'hF0, 8'hA5, 8'hAA});
        wait_drained();

        // a write drops a pending surrogate and a held byte
        write_encoding(ENC_UTF16BE);
        string_feed.push_back('{8'hD8, 1'b0});
        string_feed.push_back('{8'h00, 1'b0});
        string_feed.push_back('{8'h12, 1'b0});
        wait_drained();
        write_encoding(ENC_UTF16BE);
        push_string('{8'h00, 8'h41});
        wait_drained();

        while (string_feed.size() < 80) add_utf16_string();
        wait_drained();

        write_encoding(ENC_ROMAN);
        while (string_feed.size() < 50) add_roman_string();
        wait_drained();

        // long stretch without any idling on either side
        idle_pct = 0;
        write_encoding(ENC_UTF16BE);
        while (string_feed.size() < 55) add_utf16_string();
        wait_drained();
        idle_pct = IDLE_PCT;

        write_encoding(ENC_ROMAN);
        while (string_feed.size() < 40) add_roman_string();
        wait_drained();

        if (mismatch_count == 0 && utf8_expected.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/nsu8_pkg.sv
rtl/nsu8_front.sv
rtl/nsu8_queue.sv
rtl/nsu8_back.sv
rtl/name_string_to_utf8_transcoder_core.sv
test/tb_name_string_to_utf8_transcoder_core.sv
